// ----- design/swing_step_duration_generator_core_assert.svh -----
// ----------------------------------------------------------------------------
// swing step duration generator assertion macros
// shared concurrent assertion forms for the core
// ----------------------------------------------------------------------------
`ifndef SWING_STEP_DURATION_GENERATOR_CORE_ASSERT_SVH
`define SWING_STEP_DURATION_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SSDG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSDG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ssdg_pkg.sv -----
// ----------------------------------------------------------------------------
// ssdg_pkg
// types and constants of the swing step duration generator
// ----------------------------------------------------------------------------
package ssdg_pkg;

    // field widths
    localparam int AUDIO_RATE_W  = 18;
    localparam int TEMPO_W       = 10;
    localparam int SPB_W         = 7;
    localparam int SWING_W       = 7;
    localparam int STEP_W        = 24;
    localparam int TOTAL_W       = 40;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 18;

    // datapath widths
    localparam int NUM_W   = 32;  // audio rate * 60 * weight plus carry
    localparam int DEN_W   = 22;  // tempo * spb * 50
    localparam int NUM_B_W = 13;  // 60 * weight
    localparam int DEN_B_W = 12;  // spb * 50

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_RATE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_BEAT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_PERCENT  = 4'd3;

    // reset values
    localparam logic [AUDIO_RATE_W-1:0]  AUDIO_RATE_RST  = 18'd48000;
    localparam logic [TEMPO_W-1:0]       TEMPO_RST       = 10'd120;
    localparam logic [SPB_W-1:0]         SPB_RST         = 7'd4;
    localparam logic [SWING_W-1:0]       SWING_RST       = 7'd50;

    // substitutes and limits
    localparam logic [TEMPO_W-1:0] TEMPO_DEFAULT = 10'd120;
    localparam logic [SPB_W-1:0]   SPB_DEFAULT   = 7'd4;
    localparam logic [SPB_W-1:0]   SPB_MAX       = 7'd64;
    localparam logic [SWING_W-1:0] SWING_MIN     = 7'd50;
    localparam logic [SWING_W-1:0] SWING_MAX     = 7'd75;
    localparam logic [SWING_W-1:0] SWING_FULL    = 7'd100;
    localparam logic [NUM_B_W-1:0] SECONDS_SCALE = 13'd60;

    typedef struct packed {
        logic step_is_odd;
        logic restart;
    } in_word_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_samples;
        logic [TOTAL_W-1:0] elapsed_samples;
    } out_word_t;

endpackage

// ----- design/swing_step_duration_generator_core.sv -----
// ----------------------------------------------------------------------------
// swing_step_duration_generator_core
// sequencer step length in samples with swing and remainder carry
// ----------------------------------------------------------------------------
//  channel   signals                          direction  word
//  in        in_valid  in_stall  in_word      to core    step_is_odd, restart
//  out       out_valid out_stall out_word     from core  step_samples, elapsed_samples
//  cfg       cfg_valid cfg_ready cfg_index    to core    register index and data
//            cfg_data
//
//  from accept to result word: the serial multipliers (13-bit
//  60*weight operand), divider start, the divider (a quotient bit each),
//  quotient latch, output load; the next step is taken only once the word
//  is loaded and the core is idle again; zero audio rate skips to the accumulate state
//  reset clears carry remainder, running total and config to defaults
//  a stalled output word holds; the next step runs and waits in the accumulate state
// ----------------------------------------------------------------------------
module swing_step_duration_generator_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  ssdg_pkg::in_word_t                      in_word,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output ssdg_pkg::out_word_t                     out_word,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [ssdg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ssdg_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ssdg_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_ACC  = 2'd3;

    // configuration registers
    logic [AUDIO_RATE_W-1:0]  audio_rate_reg, audio_rate_next;
    logic [TEMPO_W-1:0]       tempo_bpm_reg, tempo_bpm_next;
    logic [SPB_W-1:0]         spb_reg, spb_next;
    logic [SWING_W-1:0]       swing_reg, swing_next;

    // step state
    logic [1:0]               state_reg, state_next;
    logic [DEN_W-1:0]         carry_reg, carry_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     out_valid_reg, out_valid_next;
    out_word_t                out_word_reg, out_word_next;

    // effective settings
    logic [TEMPO_W-1:0]       tempo_eff;
    logic [SPB_W-1:0]         spb_eff;
    logic [SWING_W-1:0]       swing_clamped;
    logic [SWING_W-1:0]       weight;
    logic                     swing_on;
    logic [NUM_B_W-1:0]       num_b;
    logic [DEN_B_W-1:0]       den_b;

    // unit handshakes
    logic                     in_take;
    logic                     mul_start;
    logic                     div_start;
    logic                     num_busy, den_busy, div_busy;
    logic [NUM_W-1:0]         num_p;
    logic [DEN_W-1:0]         den_p;
    logic [NUM_W-1:0]         div_q;
    logic [DEN_W-1:0]         div_rem;
    logic                     out_free;
    logic [TOTAL_W:0]         total_sum;

    // tempo and steps per beat substitutes, swing clamp
    always_comb
    begin
        tempo_eff = (tempo_bpm_reg == '0) ? TEMPO_DEFAULT : tempo_bpm_reg;
        if (spb_reg == '0)
        begin
            spb_eff = SPB_DEFAULT;
        end
        else if (spb_reg > SPB_MAX)
        begin
            spb_eff = SPB_MAX;
        end
        else
        begin
            spb_eff = spb_reg;
        end
        if (swing_reg < SWING_MIN)
        begin
            swing_clamped = SWING_MIN;
        end
        else if (swing_reg > SWING_MAX)
        begin
            swing_clamped = SWING_MAX;
        end
        else
        begin
            swing_clamped = swing_reg;
        end
        swing_on = (swing_clamped != SWING_MIN) && (spb_eff >= SPB_W'(2));
        weight   = in_word.step_is_odd ? (SWING_FULL - swing_clamped) : swing_clamped;
    end

    // operands, swing: 60w = 64w - 4w, 50s = 32s + 16s + 2s; no swing: 60 and spb
    always_comb
    begin
        if (swing_on)
        begin
            num_b = (NUM_B_W'(weight) << 6) - (NUM_B_W'(weight) << 2);
            den_b = (DEN_B_W'(spb_eff) << 5) + (DEN_B_W'(spb_eff) << 4)
                  + (DEN_B_W'(spb_eff) << 1);
        end
        else
        begin
            num_b = SECONDS_SCALE;
            den_b = DEN_B_W'(spb_eff);
        end
    end

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // numerator: audio rate * 60 * weight with swing, audio rate * 60 without
    ssdg_serial_mul #(
        .A_W (AUDIO_RATE_W),
        .B_W (NUM_B_W),
        .P_W (NUM_W)
    ) u_num_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (audio_rate_reg),
        .b     (num_b),
        .busy  (num_busy),
        .p     (num_p)
    );

    // denominator: tempo * spb, times 50 with swing
    ssdg_serial_mul #(
        .A_W (TEMPO_W),
        .B_W (DEN_B_W),
        .P_W (DEN_W)
    ) u_den_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (tempo_eff),
        .b     (den_b),
        .busy  (den_busy),
        .p     (den_p)
    );

    // the carried remainder rides on the numerator
    ssdg_serial_div #(
        .N_W (NUM_W),
        .D_W (DEN_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (num_p + NUM_W'(carry_reg)),
        .divisor   (den_p),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // running total with saturation at all ones
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(step_reg);

    always_comb
    begin
        state_next     = state_reg;
        carry_next     = carry_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_word.restart)
                    begin
                        carry_next = '0;
                        total_next = '0;
                    end
                    if (audio_rate_reg == '0)
                    begin
                        // zero rate: zero length, remainder kept
                        step_next  = '0;
                        state_next = S_ACC;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                if (!num_busy && !den_busy)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    step_next  = (div_q[NUM_W-1:STEP_W] != '0) ? '1 : div_q[STEP_W-1:0];
                    carry_next = div_rem;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (out_free)
                begin
                    total_next                    = total_sum[TOTAL_W] ? '1
                                                  : total_sum[TOTAL_W-1:0];
                    out_word_next.step_samples    = step_reg;
                    out_word_next.elapsed_samples = total_sum[TOTAL_W] ? '1
                                                  : total_sum[TOTAL_W-1:0];
                    out_valid_next                = 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // register writes, taken every cycle
    always_comb
    begin
        audio_rate_next  = audio_rate_reg;
        tempo_bpm_next   = tempo_bpm_reg;
        spb_next         = spb_reg;
        swing_next       = swing_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AUDIO_RATE:     audio_rate_next  = cfg_data[AUDIO_RATE_W-1:0];
                REG_TEMPO_BPM:      tempo_bpm_next   = cfg_data[TEMPO_W-1:0];
                REG_STEPS_PER_BEAT: spb_next         = cfg_data[SPB_W-1:0];
                REG_SWING_PERCENT:  swing_next       = cfg_data[SWING_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            carry_reg       <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
            audio_rate_reg  <= AUDIO_RATE_RST;
            tempo_bpm_reg   <= TEMPO_RST;
            spb_reg         <= SPB_RST;
            swing_reg       <= SWING_RST;
        end
        else
        begin
            state_reg       <= state_next;
            carry_reg       <= carry_next;
            total_reg       <= total_next;
            out_valid_reg   <= out_valid_next;
            audio_rate_reg  <= audio_rate_next;
            tempo_bpm_reg   <= tempo_bpm_next;
            spb_reg         <= spb_next;
            swing_reg       <= swing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        out_word_reg <= out_word_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

    // assertions
    `include "swing_step_duration_generator_core_assert.svh"

    `SSDG_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_take, state_reg != S_IDLE,
                      "accepted step did not start work")
    `SSDG_ASSERT_IMPL(a_div_only_in_div, clk, rst_n, div_busy, state_reg == S_DIV,
                      "divider running outside the divide state")
    `SSDG_ASSERT_IMPL(a_rem_below_den, clk, rst_n, (state_reg == S_DIV) && !div_busy,
                      div_rem < den_p, "division remainder not below denominator")
    `SSDG_ASSERT_IMPL(a_total_covers_step, clk, rst_n, out_valid_reg,
                      out_word_reg.elapsed_samples >= TOTAL_W'(out_word_reg.step_samples),
                      "running total below step length")

endmodule

// ----- design/ssdg_serial_mul.sv -----
// ----------------------------------------------------------------------------
// ssdg_serial_mul
// shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module ssdg_serial_mul #(
    parameter int A_W = ssdg_pkg::AUDIO_RATE_W,
    parameter int B_W = ssdg_pkg::NUM_B_W,
    parameter int P_W = ssdg_pkg::NUM_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           busy,
    output logic [P_W-1:0] p
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            a_next    = P_W'(a);
            b_next    = b;
            p_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                p_next = p_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule

// ----- design/ssdg_serial_div.sv -----
// ----------------------------------------------------------------------------
// ssdg_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssdg_serial_div #(
    parameter int N_W = ssdg_pkg::NUM_W,
    parameter int D_W = ssdg_pkg::DEN_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient,
    output logic [D_W-1:0] remainder
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [D_W:0]     shifted;
    logic [D_W+1:0]   diff;

    assign shifted = {rem_reg, quo_reg[N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // no borrow: the divisor fits, take a one bit
            if (!diff[D_W+1])
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
